// ===== hw/rtl/asm_pkg.sv =====
// Shared types and constants for the allocation statistics monitor.
// Command codes, size-class limits and the size-class decoder.
// No dependencies.
`default_nettype none

package asm_pkg;

  localparam int SIZE_W   = 64;
  localparam int STAT_W   = 64;
  localparam int CMD_W    = 2;
  localparam int NUM_BINS = 6;
  localparam int NUM_OUT  = 12;

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [SIZE_W-1:0]   size_t;
  typedef logic [NUM_BINS-1:0] bin_sel_t;

  // Command 3 is not defined and behaves like a read.
  localparam cmd_t CMD_ALLOC = 2'd0;
  localparam cmd_t CMD_FREE  = 2'd1;
  localparam cmd_t CMD_READ  = 2'd2;

  // Register indexes on the configuration port.
  localparam logic REG_ENABLE_COUNTING = 1'b0;

  // Upper bounds of the first five size classes; the last class is open.
  localparam size_t LIMIT_64K  = size_t'(64) << 10;
  localparam size_t LIMIT_1M   = size_t'(1) << 20;
  localparam size_t LIMIT_8M   = size_t'(8) << 20;
  localparam size_t LIMIT_64M  = size_t'(64) << 20;
  localparam size_t LIMIT_256M = size_t'(256) << 20;

  // One-hot selection of the size-class bin for an allocation size.
  function automatic bin_sel_t size_class(input size_t bytes);
    bin_sel_t sel;
    sel = '0;
    if (bytes < LIMIT_64K) begin
      sel[0] = 1'b1;
    end else if (bytes < LIMIT_1M) begin
      sel[1] = 1'b1;
    end else if (bytes < LIMIT_8M) begin
      sel[2] = 1'b1;
    end else if (bytes < LIMIT_64M) begin
      sel[3] = 1'b1;
    end else if (bytes < LIMIT_256M) begin
      sel[4] = 1'b1;
    end else begin
      sel[5] = 1'b1;
    end
    return sel;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/allocation_statistics_monitor.sv =====
// Allocation statistics monitor: event counters, byte totals, maxima and
// a six-bin size histogram, with a stream input, stream output and APB port.
// Depends on asm_pkg.
//
// Usage: each input beat carries one allocator event, the command in
// s_axis_tuser and the size in s_axis_tdata. Allocations and frees update
// the statistics while enable_counting (APB register 0, byte address 0) is
// set; a read, or any event while counting is off, changes nothing. Every
// input beat produces exactly one output beat holding a full snapshot of
// the twelve statistics after that beat's update.
// An input beat passes through the input register, then the update and
// the snapshot land together in the statistics registers, which drive
// m_axis_tdata directly. One beat is taken per cycle while the receiver
// keeps up; the update loop (a 64-bit add followed by the high-water
// compare) sets that rate. When the receiver stalls, the snapshot holds
// and the input register takes one more beat only if it is empty, after
// which s_axis_tready drops until the output moves. Reset clears all
// statistics, the enable register and both stages.
`default_nettype none

module allocation_statistics_monitor #(
  parameter int COUNT_BITS = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // Input stream.
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [63:0]                  s_axis_tdata,   // [63:0] size_bytes
  input  wire asm_pkg::cmd_t                s_axis_tuser,   // [1:0] command
  // Output stream.
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // From bit 0 up, 64 bits each: alloc_count, free_count, total_bytes_seen,
  // bytes_in_use, peak_outstanding, largest_request, hist_under_64k,
  // hist_under_1m, hist_under_8m, hist_under_64m, hist_under_256m,
  // hist_from_256m.
  output logic [767:0]                      m_axis_tdata,
  // Configuration port.
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [2:0]                   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import asm_pkg::*;

  typedef logic [COUNT_BITS-1:0] count_t;

  // Configuration.
  logic enable_counting;
  logic reg_index;
  logic cfg_write;

  // Input register.
  logic  in_valid;
  cmd_t  in_cmd;
  size_t in_size;

  // Statistics; they also serve as the result register.
  logic   out_valid;
  count_t alloc_tally;
  count_t free_tally;
  size_t  byte_sum;
  size_t  live_bytes;
  size_t  live_high_water;
  size_t  biggest_seen;
  count_t bin_tally [NUM_BINS];

  logic     advance;
  logic     do_alloc;
  logic     do_free;
  size_t    live_added;
  size_t    live_next;
  bin_sel_t bin_sel;

  assign pready    = 1'b1;
  assign reg_index = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_counting <= 1'b0;
    end else if (cfg_write && reg_index == REG_ENABLE_COUNTING) begin
      enable_counting <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_index == REG_ENABLE_COUNTING) begin
      prdata[0] = enable_counting;
    end
  end

  // The statistics move whenever a beat is held and the output slot is free or being emptied.
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd  <= s_axis_tuser;
      in_size <= s_axis_tdata;
    end
  end

  assign do_alloc   = advance && enable_counting && in_cmd == CMD_ALLOC;
  assign do_free    = advance && enable_counting && in_cmd == CMD_FREE;
  assign live_added = live_bytes + in_size;
  assign bin_sel    = size_class(in_size);

  always_comb begin
    live_next = live_bytes;
    if (do_alloc) begin
      live_next = live_added;
    end else if (do_free) begin
      live_next = live_bytes - in_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alloc_tally     <= '0;
      free_tally      <= '0;
      byte_sum        <= '0;
      live_bytes      <= '0;
      live_high_water <= '0;
      biggest_seen    <= '0;
    end else begin
      live_bytes <= live_next;
      if (do_alloc) begin
        alloc_tally <= alloc_tally + count_t'(1);
        byte_sum    <= byte_sum + in_size;
        if (live_added > live_high_water) begin
          live_high_water <= live_added;
        end
        if (in_size > biggest_seen) begin
          biggest_seen <= in_size;
        end
      end
      if (do_free) begin
        free_tally <= free_tally + count_t'(1);
      end
    end
  end

  for (genvar k = 0; k < NUM_BINS; k++) begin : g_bin
    always_ff @(posedge clk) begin
      if (rst) begin
        bin_tally[k] <= '0;
      end else if (do_alloc && bin_sel[k]) begin
        bin_tally[k] <= bin_tally[k] + count_t'(1);
      end
    end
    assign m_axis_tdata[(6+k)*STAT_W +: STAT_W] = STAT_W'(bin_tally[k]);
  end

  assign m_axis_tdata[0*STAT_W +: STAT_W] = STAT_W'(alloc_tally);
  assign m_axis_tdata[1*STAT_W +: STAT_W] = STAT_W'(free_tally);
  assign m_axis_tdata[2*STAT_W +: STAT_W] = byte_sum;
  assign m_axis_tdata[3*STAT_W +: STAT_W] = live_bytes;
  assign m_axis_tdata[4*STAT_W +: STAT_W] = live_high_water;
  assign m_axis_tdata[5*STAT_W +: STAT_W] = biggest_seen;

  // Every counted allocation lands in exactly one bin.
  a_bins_match_allocs: assert property (@(posedge clk) disable iff (rst)
    count_t'(bin_tally[0] + bin_tally[1] + bin_tally[2] + bin_tally[3] +
              bin_tally[4] + bin_tally[5]) == alloc_tally)
    else $error("histogram bins do not add up to the allocation count");

  // The high-water mark only ever rises outside reset.
  a_peak_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && live_high_water != $past(live_high_water)
      |-> live_high_water > $past(live_high_water))
    else $error("high-water mark decreased");

  // Statistics only change while a beat moves into the output slot.
  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(alloc_tally) && $stable(free_tally) &&
                 $stable(live_bytes) && $stable(byte_sum))
    else $error("statistics changed without a beat");

  // A counted allocation bumps the allocation count by one.
  a_alloc_counts: assert property (@(posedge clk) disable iff (rst)
    do_alloc |=> alloc_tally == count_t'($past(alloc_tally) + count_t'(1)))
    else $error("allocation not counted");

  // Counting disabled leaves the live count and the largest request alone.
  a_disabled_frozen: assert property (@(posedge clk) disable iff (rst)
    advance && !enable_counting |=> $stable(live_bytes) && $stable(biggest_seen))
    else $error("statistics changed while counting was disabled");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for allocation_statistics_monitor.
// A queue-fed stream driver with a statistics predictor, a snapshot checker, APB writes.
// Depends on asm_pkg and the monitor RTL.
`default_nettype none

module tb;
  import asm_pkg::*;

  localparam int          COUNT_BITS  = 64;
  localparam logic [63:0] COUNT_MASK  = {64{1'b1}} >> (64 - COUNT_BITS);
  localparam cmd_t        CMD_UNUSED  = 2'd3;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          HOLD_CYCLES = 300;
  localparam int          CHUNKS      = 15;
  localparam int          CHUNK_ITEMS = 110;

  typedef struct packed {
    cmd_t        cmd;
    logic [63:0] bytes;
  } alloc_event_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata = '0;   // [63:0] size_bytes
  cmd_t         s_axis_tuser = CMD_ALLOC;   // [1:0] command
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // From bit 0 up, 64 bits each: alloc_count, free_count, total_bytes_seen,
  // bytes_in_use, peak_outstanding, largest_request, hist_under_64k,
  // hist_under_1m, hist_under_8m, hist_under_64m, hist_under_256m,
  // hist_from_256m.
  logic [767:0] m_axis_tdata;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  // Predicted statistics.
  logic        count_enable = 1'b0;
  logic [63:0] n_alloc = '0;
  logic [63:0] n_free = '0;
  logic [63:0] byte_total = '0;
  logic [63:0] live_now = '0;
  logic [63:0] live_peak = '0;
  logic [63:0] biggest = '0;
  logic [63:0] bin_tally [NUM_BINS];

  alloc_event_t pending_events[$];
  logic [767:0] snapshot_q[$];
  logic [63:0]  live_sizes[$];

  int          errors = 0;
  int          cycle_count = 0;
  int          idle_mode = 0;
  logic        hold_flip = 1'b0;

  string field_names [NUM_OUT] = '{"alloc_count", "free_count", "total_bytes_seen",
    "bytes_in_use", "peak_outstanding", "largest_request", "hist_under_64k",
    "hist_under_1m", "hist_under_8m", "hist_under_64m", "hist_under_256m",
    "hist_from_256m"};

  allocation_statistics_monitor #(.COUNT_BITS(COUNT_BITS)) u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Applies one accepted event to the predicted statistics and queues the snapshot.
  task automatic record_event(input cmd_t cmd, input logic [63:0] bytes);
    int unsigned bin;
    bin = (bytes >= LIMIT_64K) + (bytes >= LIMIT_1M) + (bytes >= LIMIT_8M) +
          (bytes >= LIMIT_64M) + (bytes >= LIMIT_256M);
    if (count_enable) begin
      if (cmd == CMD_ALLOC) begin
        n_alloc = (n_alloc + 64'd1) & COUNT_MASK;
        byte_total = byte_total + bytes;
        bin_tally[bin] = (bin_tally[bin] + 64'd1) & COUNT_MASK;
        live_now = live_now + bytes;
        if (live_now > live_peak) live_peak = live_now;
        if (bytes > biggest) biggest = bytes;
      end else if (cmd == CMD_FREE) begin
        n_free = (n_free + 64'd1) & COUNT_MASK;
        live_now = live_now - bytes;
      end
    end
    snapshot_q.push_back({bin_tally[5], bin_tally[4], bin_tally[3], bin_tally[2],
                          bin_tally[1], bin_tally[0], biggest, live_peak, live_now,
                          byte_total, n_free, n_alloc});
  endtask

  initial begin
    for (int k = 0; k < NUM_BINS; k++) bin_tally[k] = '0;
  end

  // Stream driver: a beat is predicted when accepted, and the next one offered.
  always @(posedge clk) begin : drive_events
    alloc_event_t nxt;
    int unsigned  draw;
    logic         gap;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) record_event(s_axis_tuser, s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        draw = $urandom_range(99);
        gap = (idle_mode == 0 && draw < 34) || (idle_mode == 1 && draw < 58);
        if (pending_events.size() != 0 && !gap) begin
          nxt = pending_events.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= nxt.cmd;
          s_axis_tdata <= nxt.bytes;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Snapshot checker and receiver back-pressure.
  always @(posedge clk) begin : check_snapshots
    logic [767:0] want;
    int unsigned  draw;
    int           hold_left;
    logic         hold_seen;
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_left = 0;
      hold_seen = hold_flip;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (snapshot_q.size() == 0) begin
          $error("snapshot beat with no expectation waiting");
          errors++;
        end else begin
          want = snapshot_q.pop_front();
          for (int i = 0; i < NUM_OUT; i++) begin
            if (m_axis_tdata[64*i +: 64] !== want[64*i +: 64]) begin
              $error("%s: expected %0d, actual %0d", field_names[i],
                     want[64*i +: 64], m_axis_tdata[64*i +: 64]);
              errors++;
            end
          end
        end
      end
      if (hold_seen != hold_flip) begin
        hold_seen = hold_flip;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        draw = $urandom_range(99);
        m_axis_tready <= !((idle_mode == 0 && draw < 58) || (idle_mode == 1 && draw < 34));
      end
    end
  end

  task automatic push_event(input cmd_t cmd, input logic [63:0] bytes);
    alloc_event_t ev;
    ev.cmd = cmd;
    ev.bytes = bytes;
    pending_events.push_back(ev);
  endtask

  // Waits until every queued beat has gone in and every snapshot has come back.
  task automatic drain();
    while (pending_events.size() != 0 || snapshot_q.size() != 0 || s_axis_tvalid)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_enable(input logic value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {REG_ENABLE_COUNTING, 2'b00};
    pwdata <= {31'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    count_enable <= value;
  endtask

  function automatic logic [63:0] class_limit(input int unsigned k);
    case (k)
      0: return LIMIT_64K;
      1: return LIMIT_1M;
      2: return LIMIT_8M;
      3: return LIMIT_64M;
      default: return LIMIT_256M;
    endcase
  endfunction

  function automatic logic [63:0] pick_size();
    case ($urandom_range(5))
      0: return 64'($urandom_range(65535));
      1: return class_limit($urandom_range(4)) + 64'($urandom_range(2)) - 64'd1;
      2: return 64'($urandom_range(32'h1000_0000));
      3: return {$urandom, $urandom};
      4: return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(3));
      default: return 64'd1 << $urandom_range(63);
    endcase
  endfunction

  // Mostly allocations and frees of live blocks, with stray frees, reads and undefined commands mixed in.
  task automatic push_random_chunk();
    int unsigned r;
    int unsigned pick;
    logic [63:0] sz;
    for (int n = 0; n < CHUNK_ITEMS; n++) begin
      r = $urandom_range(99);
      if (r < 45) begin
        sz = pick_size();
        push_event(CMD_ALLOC, sz);
        if (live_sizes.size() < 64) live_sizes.push_back(sz);
      end else if (r < 80) begin
        if (live_sizes.size() != 0 && $urandom_range(3) != 0) begin
          pick = $urandom_range(live_sizes.size() - 1);
          sz = live_sizes[pick];
          live_sizes.delete(pick);
        end else begin
          sz = pick_size();
        end
        push_event(CMD_FREE, sz);
      end else if (r < 92) begin
        push_event(CMD_READ, pick_size());
      end else begin
        push_event(CMD_UNUSED, pick_size());
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    write_enable(1'b1);

    @(negedge clk);
    push_event(CMD_ALLOC, 64'd0);
    for (int k = 0; k < 5; k++) begin
      push_event(CMD_ALLOC, class_limit(k) - 64'd1);
      push_event(CMD_ALLOC, class_limit(k));
    end
    push_event(CMD_ALLOC, 64'hFFFF_FFFF_FFFF_FFFF);
    push_event(CMD_READ, 64'hFFFF_FFFF_FFFF_FFFF);
    push_event(CMD_UNUSED, 64'h5555_AAAA_5555_AAAA);
    // Free more than is live, so the live count wraps, then allocate again.
    push_event(CMD_FREE, 64'hFFFF_FFFF_FFFF_FFFF);
    push_event(CMD_FREE, 64'h8000_0000_0000_0000);
    push_event(CMD_ALLOC, 64'h0000_0000_0000_0010);
    push_event(CMD_ALLOC, 64'h8000_0000_0000_0000);
    push_event(CMD_FREE, 64'd0);
    drain();

    // With counting off nothing moves, yet each beat still returns a snapshot.
    write_enable(1'b0);
    @(negedge clk);
    push_event(CMD_ALLOC, 64'd4096);
    push_event(CMD_FREE, 64'd4096);
    push_event(CMD_READ, 64'd0);
    push_event(CMD_ALLOC, 64'hFFFF_FFFF_FFFF_FFFF);
    drain();

    for (int c = 0; c < CHUNKS; c++) begin
      write_enable((c % 4) != 3);
      idle_mode <= c / 5;
      @(negedge clk);
      push_random_chunk();
      // A long receiver stall while the sender keeps offering beats.
      if (c == 2) hold_flip <= ~hold_flip;
      drain();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
